@@ sv/assert_macros.svh @@
// Assertion macros for the stencil block.
// Expects signals named clock and reset in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ISG_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ISG_ASSERT_NR(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/isg_pkg.sv @@
// Shared constants, register codes and types of the stencil block.
// No dependencies.
`timescale 1ns / 1ps

package isg_pkg;

   // Defaults of the top-level parameters
   localparam int MAX_ROW_LENGTH_DEF = 1024;
   localparam int SAMPLE_BITS_DEF    = 24;

   // Register port and field widths
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 17;
   localparam int ROW_LEN_W      = 11;
   localparam int WEIGHT_W       = 17;
   localparam int RES_W          = 32;
   localparam int UNITY_SHIFT    = 16;  // one in Q1.16
   localparam int MIN_ROW_LENGTH = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAP_DIAG_WEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAP_SCALE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAD_DIAG_WEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAD_SCALE       = 3'd4;

   // Register reset values
   localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST       = 11'd1024;
   localparam logic [WEIGHT_W-1:0]  LAP_DIAG_WEIGHT_RST  = 17'd32768;
   localparam logic [WEIGHT_W-1:0]  LAP_SCALE_RST        = 17'd32768;
   localparam logic [WEIGHT_W-1:0]  GRAD_DIAG_WEIGHT_RST = 17'd16384;
   localparam logic [WEIGHT_W-1:0]  GRAD_SCALE_RST       = 17'd21845;

   // Saturation bounds of a result field
   localparam logic signed [RES_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [RES_W-1:0] RES_MIN = 32'sh8000_0000;

   // Pipeline control from the buffer stage to the arithmetic
   typedef struct packed {
      logic advance;  // all arithmetic stages move
      logic load;     // the item entering stage two yields a result
   } pipe_ctl_type;

   // Weights and scales
   typedef struct packed {
      logic [WEIGHT_W-1:0] lap_w;
      logic [WEIGHT_W-1:0] lap_s;
      logic [WEIGHT_W-1:0] grad_w;
      logic [WEIGHT_W-1:0] grad_s;
   } coef_type;

   // Output register contents
   typedef struct packed {
      logic                    valid;
      logic signed [RES_W-1:0] grad_x;
      logic signed [RES_W-1:0] grad_y;
      logic signed [RES_W-1:0] laplacian;
   } result_type;

endpackage

@@ sv/isg_if.sv @@
// Valid/ready channel interfaces for the stencil block: samples in, results out.
// Depends on isg_pkg.
`timescale 1ns / 1ps

interface isg_req_if import isg_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          frame_start;

   modport source (output valid, output sample, output frame_start, input ready);
   modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface isg_rsp_if import isg_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [RES_W-1:0] grad_x;
   logic signed [RES_W-1:0] grad_y;
   logic signed [RES_W-1:0] laplacian;

   modport source (output valid, output grad_x, output grad_y, output laplacian, input ready);
   modport sink   (input valid, input grad_x, input grad_y, input laplacian, output ready);
endinterface

@@ sv/isg_stencil.sv @@
// Stencil arithmetic pipeline: differences, weight products, sums, scaling,
// rounding and saturation, ending in the output register. Depends on isg_pkg.
`timescale 1ns / 1ps

module isg_stencil import isg_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pipe_ctl_type                  ctl,
   input  coef_type                      coef,
   input  logic signed [SAMPLE_BITS-1:0] tap_mm,
   input  logic signed [SAMPLE_BITS-1:0] tap_cm,
   input  logic signed [SAMPLE_BITS-1:0] tap_pm,
   input  logic signed [SAMPLE_BITS-1:0] tap_m0,
   input  logic signed [SAMPLE_BITS-1:0] tap_c0,
   input  logic signed [SAMPLE_BITS-1:0] tap_p0,
   input  logic signed [SAMPLE_BITS-1:0] tap_mp,
   input  logic signed [SAMPLE_BITS-1:0] tap_cp,
   input  logic signed [SAMPLE_BITS-1:0] tap_pp,
   output result_type                    res
);

   localparam int DW    = SAMPLE_BITS + 2;             // four-term sums
   localparam int SW    = WEIGHT_W + 1;                // weight as signed
   localparam int PW    = DW + SW;                     // diagonal products
   localparam int CW    = SAMPLE_BITS + SW + 1;        // centre product
   localparam int ACC_W = SAMPLE_BITS + 22;            // Q.36 sums
   localparam int LO_W  = 23;
   localparam int HI_W  = ACC_W - LO_W;
   localparam int LOP_W = LO_W + WEIGHT_W;
   localparam int HIP_W = HI_W + SW;
   localparam int FW    = ACC_W + SW;                  // Q.52 product
   localparam int DROP  = 2 * UNITY_SHIFT;             // Q.52 down to Q.20
   localparam int RW    = FW - DROP;
   localparam int XW    = (RW > RES_W + 1) ? RW : RES_W + 1;
   localparam int LANES = 3;
   localparam int LANE_GX = 0;
   localparam int LANE_GY = 1;
   localparam int LANE_LP = 2;
   localparam logic signed [FW-1:0] ROUND = FW'(1) <<< (DROP - 1);

   // Clamp a rounded value to the 32-bit result range
   function automatic logic signed [RES_W-1:0] sat(input logic signed [RW-1:0] v);
      logic signed [XW-1:0] x;
      x = XW'(v);
      if (x > XW'(RES_MAX)) begin
         sat = RES_MAX;
      end else if (x < XW'(RES_MIN)) begin
         sat = RES_MIN;
      end else begin
         sat = RES_W'(x);
      end
   endfunction

   logic signed [SW-1:0] gw_s;
   logic signed [SW-1:0] lw_s;
   logic signed [SW:0]   ctr_w_s;
   assign gw_s    = $signed({1'b0, coef.grad_w});
   assign lw_s    = $signed({1'b0, coef.lap_w});
   assign ctr_w_s = $signed({2'b00, coef.lap_w} + {1'b0, SW'(1) << UNITY_SHIFT});

   // Stage 2: axis and diagonal differences, and the Laplacian sums
   logic                 v2_ff;
   logic signed [DW-1:0] d_gx_ax_ff, d_gx_dg_ff, d_gy_ax_ff, d_gy_dg_ff;
   logic signed [DW-1:0] d_lp_ax_ff, d_lp_dg_ff;
   logic signed [SAMPLE_BITS-1:0] d_ctr_ff;
   logic signed [DW-1:0] d_gx_ax_in, d_gx_dg_in, d_gy_ax_in, d_gy_dg_in;
   logic signed [DW-1:0] d_lp_ax_in, d_lp_dg_in;

   always_comb begin
      d_gx_ax_in = DW'(tap_p0) - DW'(tap_m0);
      d_gx_dg_in = DW'(tap_pp) - DW'(tap_mp) + DW'(tap_pm) - DW'(tap_mm);
      d_gy_ax_in = DW'(tap_cp) - DW'(tap_cm);
      d_gy_dg_in = DW'(tap_pp) - DW'(tap_pm) + DW'(tap_mp) - DW'(tap_mm);
      d_lp_ax_in = DW'(tap_p0) + DW'(tap_m0) + DW'(tap_cp) + DW'(tap_cm);
      d_lp_dg_in = DW'(tap_pp) + DW'(tap_pm) + DW'(tap_mp) + DW'(tap_mm);
   end

   // Stage 3: weight products, axis terms carried along
   logic                 v3_ff;
   logic signed [DW-1:0] a_gx_ff, a_gy_ff, a_lp_ff;
   logic signed [PW-1:0] p_gx_ff, p_gy_ff, p_lp_ff;
   logic signed [CW-1:0] p_ctr_ff;

   // Stage 4: Q.36 sums
   logic                    v4_ff;
   logic signed [ACC_W-1:0] acc_ff [LANES];
   logic signed [ACC_W-1:0] acc_in [LANES];

   always_comb begin
      acc_in[LANE_GX] = (ACC_W'(a_gx_ff) <<< UNITY_SHIFT) + ACC_W'(p_gx_ff);
      acc_in[LANE_GY] = (ACC_W'(a_gy_ff) <<< UNITY_SHIFT) + ACC_W'(p_gy_ff);
      acc_in[LANE_LP] = (ACC_W'(a_lp_ff) <<< UNITY_SHIFT) + ACC_W'(p_lp_ff)
                        - (ACC_W'(p_ctr_ff) <<< 2);
   end

   // Stage 5: scale products, split into low and high partial products
   logic                    v5_ff;
   logic        [LOP_W-1:0] lo_p_ff [LANES];
   logic signed [HIP_W-1:0] hi_p_ff [LANES];
   logic        [LOP_W-1:0] lo_p_in [LANES];
   logic signed [HIP_W-1:0] hi_p_in [LANES];
   logic     [WEIGHT_W-1:0] lane_scale [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         lane_scale[i] = (i == LANE_LP) ? coef.lap_s : coef.grad_s;
         lo_p_in[i] = LOP_W'(acc_ff[i][LO_W-1:0]) * LOP_W'(lane_scale[i]);
         hi_p_in[i] = HIP_W'($signed(acc_ff[i][ACC_W-1:LO_W]))
                      * HIP_W'($signed({1'b0, lane_scale[i]}));
      end
   end

   // Stage 6: recombine, round to nearest with ties up, drop to Q.20
   logic                 v6_ff;
   logic signed [RW-1:0] rnd_ff [LANES];
   logic signed [RW-1:0] rnd_in [LANES];
   logic signed [FW-1:0] full [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         full[i] = (FW'(hi_p_ff[i]) <<< LO_W) + $signed(FW'({1'b0, lo_p_ff[i]})) + ROUND;
         rnd_in[i] = full[i][FW-1:DROP];
      end
   end

   // Output register with saturation
   result_type res_ff;
   result_type res_in;

   always_comb begin
      res_in.valid     = v6_ff;
      res_in.grad_x    = sat(rnd_ff[LANE_GX]);
      res_in.grad_y    = sat(rnd_ff[LANE_GY]);
      res_in.laplacian = sat(rnd_ff[LANE_LP]);
   end

   // Valid bits and payload of all stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         res_ff.valid <= 1'b0;
      end else if (ctl.advance) begin
         v2_ff        <= ctl.load;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         res_ff.valid <= res_in.valid;
      end

      if (ctl.advance) begin
         d_gx_ax_ff <= d_gx_ax_in;
         d_gx_dg_ff <= d_gx_dg_in;
         d_gy_ax_ff <= d_gy_ax_in;
         d_gy_dg_ff <= d_gy_dg_in;
         d_lp_ax_ff <= d_lp_ax_in;
         d_lp_dg_ff <= d_lp_dg_in;
         d_ctr_ff   <= tap_c0;

         a_gx_ff  <= d_gx_ax_ff;
         a_gy_ff  <= d_gy_ax_ff;
         a_lp_ff  <= d_lp_ax_ff;
         p_gx_ff  <= PW'(d_gx_dg_ff) * PW'(gw_s);
         p_gy_ff  <= PW'(d_gy_dg_ff) * PW'(gw_s);
         p_lp_ff  <= PW'(d_lp_dg_ff) * PW'(lw_s);
         p_ctr_ff <= CW'(d_ctr_ff) * CW'(ctr_w_s);

         for (int i = 0; i < LANES; i++) begin
            acc_ff[i]  <= acc_in[i];
            lo_p_ff[i] <= lo_p_in[i];
            hi_p_ff[i] <= hi_p_in[i];
            rnd_ff[i]  <= rnd_in[i];
         end

         res_ff.grad_x    <= res_in.grad_x;
         res_ff.grad_y    <= res_in.grad_y;
         res_ff.laplacian <= res_in.laplacian;
      end
   end

   assign res = res_ff;

endmodule

@@ sv/isotropic_stencil_gradient_laplacian.sv @@
// Nine-point isotropic gradient and Laplacian stencil, top level.
//
// req_ch takes one Q3.20 sample per item in raster order; frame_start marks
// row 0, column 0 of a grid. rsp_ch gives grad_x, grad_y and laplacian (Q11.20,
// saturated) for every site whose full 3x3 neighbourhood has arrived; samples in
// the first two rows of a frame or the first two columns of a row give none.
// The csr_ port writes row_length and the four weights; write only while idle.
//
// Each sample reads both line buffers at its column when accepted; the rows
// are written back when the pipeline advances, and only after that is a new
// sample taken. A result passes the buffer-read stage, stages 2 to 6 and out.
//
// Reset clears the position counters, the window, the registers (to their
// defaults) and the pipeline. The line buffers are not cleared; the first two
// rows of each frame fill them before any result reads them.
// A stalled rsp_ch freezes the arithmetic pipeline; req_ch still takes one
// item into the buffer-read stage and then holds ready low.
// Depends on isg_pkg, isg_if, isg_stencil and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module isotropic_stencil_gradient_laplacian import isg_pkg::*; #(
   parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF,
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   isg_req_if.sink               req_ch,
   isg_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW    = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
   localparam int LEN_W = (AW + 1 > ROW_LEN_W) ? AW + 1 : ROW_LEN_W;
   localparam logic [1:0] ROW_FULL = 2'd2;

   // Configuration registers
   logic [ROW_LEN_W-1:0] row_length_ff;
   coef_type             coef_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff  <= ROW_LENGTH_RST;
         coef_ff.lap_w  <= LAP_DIAG_WEIGHT_RST;
         coef_ff.lap_s  <= LAP_SCALE_RST;
         coef_ff.grad_w <= GRAD_DIAG_WEIGHT_RST;
         coef_ff.grad_s <= GRAD_SCALE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ROW_LENGTH:       row_length_ff  <= csr_wdata[ROW_LEN_W-1:0];
            CSR_LAP_DIAG_WEIGHT:  coef_ff.lap_w  <= csr_wdata[WEIGHT_W-1:0];
            CSR_LAP_SCALE:        coef_ff.lap_s  <= csr_wdata[WEIGHT_W-1:0];
            CSR_GRAD_DIAG_WEIGHT: coef_ff.grad_w <= csr_wdata[WEIGHT_W-1:0];
            CSR_GRAD_SCALE:       coef_ff.grad_s <= csr_wdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective row length, clamped to the supported range
   logic [LEN_W-1:0] len_raw;
   logic [LEN_W-1:0] eff_len;

   always_comb begin
      len_raw = LEN_W'(row_length_ff);
      if (len_raw < LEN_W'(MIN_ROW_LENGTH)) begin
         eff_len = LEN_W'(MIN_ROW_LENGTH);
      end else if (len_raw > LEN_W'(MAX_ROW_LENGTH)) begin
         eff_len = LEN_W'(MAX_ROW_LENGTH);
      end else begin
         eff_len = len_raw;
      end
   end

   // Handshake and stall
   logic       accept;
   logic       advance;
   logic       s1_valid_ff;
   result_type res;

   assign req_ch.ready = !s1_valid_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign advance      = !res.valid || rsp_ch.ready;

   // Raster position of the incoming item
   logic [AW-1:0] col_ff, col_in, col_cur;
   logic [1:0]    row_ff, row_in, row_cur;
   logic          produce_in;
   logic          wrap;

   always_comb begin
      col_cur    = req_ch.frame_start ? '0 : col_ff;
      row_cur    = req_ch.frame_start ? '0 : row_ff;
      produce_in = (row_cur >= ROW_FULL) && (col_cur >= AW'(2));
      wrap       = (LEN_W'(col_cur) + LEN_W'(1)) >= eff_len;
      col_in     = wrap ? '0 : col_cur + AW'(1);
      row_in     = (wrap && (row_cur < ROW_FULL)) ? row_cur + 2'd1 : row_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Buffer-read stage: holds one item until its column is written back
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [AW-1:0]                 s1_addr_ff;
   logic                          s1_produce_ff;
   logic                          wr_en;

   assign wr_en = s1_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff  <= req_ch.sample;
         s1_addr_ff    <= col_cur;
         s1_produce_ff <= produce_in;
      end
   end

   // Line buffers: read at accept, rows shifted down at write-back
   logic signed [SAMPLE_BITS-1:0] upper_mem  [MAX_ROW_LENGTH];
   logic signed [SAMPLE_BITS-1:0] middle_mem [MAX_ROW_LENGTH];
   logic signed [SAMPLE_BITS-1:0] up_q_ff;
   logic signed [SAMPLE_BITS-1:0] mid_q_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         up_q_ff  <= upper_mem[col_cur];
         mid_q_ff <= middle_mem[col_cur];
      end
      if (wr_en) begin
         upper_mem[s1_addr_ff]  <= mid_q_ff;
         middle_mem[s1_addr_ff] <= s1_sample_ff;
      end
   end

   // Window of the two previous columns: rows M, C, P
   logic signed [SAMPLE_BITS-1:0] win_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (wr_en) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= up_q_ff;
         win_ff[4] <= mid_q_ff;
         win_ff[5] <= s1_sample_ff;
      end
   end

   // Arithmetic pipeline
   pipe_ctl_type ctl;

   assign ctl.advance = advance;
   assign ctl.load    = s1_valid_ff && s1_produce_ff;

   isg_stencil #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_stencil (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .coef   (coef_ff),
      .tap_mm (win_ff[0]),
      .tap_cm (win_ff[1]),
      .tap_pm (win_ff[2]),
      .tap_m0 (win_ff[3]),
      .tap_c0 (win_ff[4]),
      .tap_p0 (win_ff[5]),
      .tap_mp (up_q_ff),
      .tap_cp (mid_q_ff),
      .tap_pp (s1_sample_ff),
      .res    (res)
   );

   assign rsp_ch.valid     = res.valid;
   assign rsp_ch.grad_x    = res.grad_x;
   assign rsp_ch.grad_y    = res.grad_y;
   assign rsp_ch.laplacian = res.laplacian;

   // Checks
   `ISG_ASSERT(a_row_sat, row_ff <= ROW_FULL, "row count beyond two")
   `ISG_ASSERT(a_one_read, s1_valid_ff |-> !accept, "item accepted over a pending write-back")
   `ISG_ASSERT(a_read_hold, s1_valid_ff && !advance |=> $stable(up_q_ff) && $stable(mid_q_ff), "buffer read data lost while stalled")
   `ISG_ASSERT(a_frame_no_res, accept && req_ch.frame_start |=> !s1_produce_ff, "frame start item marked for a result")
   `ISG_ASSERT_NR(a_reset_empty, $past(reset) |-> !res.valid, "result valid right after reset")

endmodule
